### design/mpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: shared types and constants
// Field widths and the stage-to-stage bundles used by the averaging pipeline.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int SENSOR_W = 3;
  localparam int CODE_W   = 10;
  localparam int Q_W      = 16;
  localparam int SUM_W    = 18;

  // 100 percent in signed Q8.8
  localparam logic signed [Q_W-1:0] FULL_Q88 = 16'sd25600;

  typedef logic [SENSOR_W-1:0] sensor_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic signed [Q_W-1:0]   q88_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // calibrated sample on its way to the accumulator
  typedef struct packed {
    logic    valid;
    sensor_t sensor;
    q88_t    sample;
    logic    over;
  } sample_t;

  // completed group on its way to the averaging divider
  typedef struct packed {
    logic    valid;
    sensor_t sensor;
    sum_t    sum;
    logic    clamp;
  } group_t;

endpackage
`default_nettype wire

### design/mpa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: sample channel
// Valid/ready channel carrying one converter reading and its sensor number.
// ----------------------------------------------------------------------------
interface mpa_in_if;
  import mpa_pkg::*;

  logic    valid;
  logic    ready;
  sensor_t sensor_id;
  code_t   adc_code;

  modport source (output valid, output sensor_id, output adc_code, input ready);
  modport sink   (input valid, input sensor_id, input adc_code, output ready);
endinterface
`default_nettype wire

### design/mpa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: result channel
// Valid/ready channel carrying one per-sensor average and its clamp flag.
// ----------------------------------------------------------------------------
interface mpa_out_if;
  import mpa_pkg::*;

  logic    valid;
  logic    ready;
  sensor_t sensor_out;
  q88_t    moisture_avg;
  logic    clamped;

  modport source (output valid, output sensor_out, output moisture_avg, output clamped,
                  input ready);
  modport sink   (input valid, input sensor_out, input moisture_avg, input clamped,
                  output ready);
endinterface
`default_nettype wire

### design/moisture_adc_piecewise_average_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Soil moisture calibration and per-sensor averaging
// Converts converter codes to water-content percent and averages per sensor.
// ----------------------------------------------------------------------------
// Usage:
//   adc carries one request per sample: sensor_id and a 10-bit adc_code.
//   avg carries one result after every SAMPLES_PER_AVERAGE samples of a
//   sensor: sensor_out, moisture_avg (signed Q8.8, truncated toward zero)
//   and clamped (some sample of the group was above 3.0 V, taken as 100%).
//   Samples from a sensor number not below SENSOR_COUNT are dropped.
//   Throughput: one request per cycle while avg is not stalled.
//   Calibration, accumulation and averaging run as a five-register
//   pipeline (input, numerator, sample, group, output).
//   When avg is stalled the whole pipeline holds and adc.ready falls; it
//   rises again in the cycle the waiting result is taken.
//   Reset clears every sensor's count, sum and clamp flag and empties the
//   pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module moisture_adc_piecewise_average_unit #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int SENSOR_COUNT        = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  mpa_in_if.sink    adc,
  mpa_out_if.source avg
);
  import mpa_pkg::*;

  logic    en;
  sample_t smp;
  group_t  grp;

  // advance while the output register is empty or being taken
  assign en        = !avg.valid || avg.ready;
  assign adc.ready = en;

  mpa_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (adc.valid),
    .in_sensor (adc.sensor_id),
    .in_code   (adc.adc_code),
    .smp       (smp)
  );

  mpa_accum #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SENSOR_COUNT        (SENSOR_COUNT)
  ) u_accum (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .smp (smp),
    .grp (grp)
  );

  mpa_avgdiv #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_avgdiv (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .grp          (grp),
    .valid        (avg.valid),
    .sensor_out   (avg.sensor_out),
    .moisture_avg (avg.moisture_avg),
    .clamped      (avg.clamped)
  );

endmodule
`default_nettype wire

### design/mpa_calib.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: calibration pipeline
// Input register, segment selection with the linear numerator, then an exact
// rounded division by a reciprocal multiply into a signed Q8.8 sample.
// ----------------------------------------------------------------------------
module mpa_calib (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire mpa_pkg::sensor_t in_sensor,
  input  wire mpa_pkg::code_t   in_code,
  output mpa_pkg::sample_t      smp
);
  import mpa_pkg::*;

  // segment tops in converter codes
  localparam code_t SEG1_TOP = 10'd225;
  localparam code_t SEG2_TOP = 10'd265;
  localparam code_t SEG3_TOP = 10'd372;
  localparam code_t SEG4_TOP = 10'd450;
  localparam code_t SEG5_TOP = 10'd613;

  // Q8.8 value = round((A * code - B) / 25575), A = slope*320, B = offset*65472
  localparam logic [20:0] A1 = 21'd320000;
  localparam logic [20:0] A2 = 21'd800000;
  localparam logic [20:0] A3 = 21'd1538560;
  localparam logic [20:0] A4 = 21'd842240;
  localparam logic [20:0] A5 = 21'd2000000;
  localparam logic [29:0] B1 = 30'd6547200;
  localparam logic [29:0] B2 = 30'd114576000;
  localparam logic [29:0] B3 = 30'd310992000;
  localparam logic [29:0] B4 = 30'd51657408;
  localparam logic [29:0] B5 = 30'd572880000;

  localparam logic [29:0] ROUND_BIAS = 30'd12787;
  // ceil(2^45 / 25575): exact floor division for dividends below 2^30
  localparam logic [30:0] RECIP      = 31'd1375733025;
  localparam int          RECIP_SH   = 45;

  // stage 1: input register
  logic    s1_valid;
  sensor_t s1_sensor;
  code_t   s1_code;

  // stage 2: rounded magnitude of the numerator
  logic        s2_valid;
  sensor_t     s2_sensor;
  logic        s2_over;
  logic        s2_neg;
  logic [29:0] s2_x;

  // stage 3: finished sample
  logic    s3_valid;
  sensor_t s3_sensor;
  q88_t    s3_sample;
  logic    s3_over;

  logic [20:0]        coef_a;
  logic [29:0]        coef_b;
  logic               over;
  logic [30:0]        lin;
  logic signed [31:0] diff;
  logic [31:0]        mag;
  logic [29:0]        x;
  logic [60:0]        prod;
  logic [14:0]        quot;
  q88_t               sample;

  always_comb begin
    over   = 1'b0;
    coef_a = A5;
    coef_b = B5;
    priority if (s1_code <= SEG1_TOP) begin
      coef_a = A1;
      coef_b = B1;
    end else if (s1_code <= SEG2_TOP) begin
      coef_a = A2;
      coef_b = B2;
    end else if (s1_code <= SEG3_TOP) begin
      coef_a = A3;
      coef_b = B3;
    end else if (s1_code <= SEG4_TOP) begin
      coef_a = A4;
      coef_b = B4;
    end else if (s1_code <= SEG5_TOP) begin
      coef_a = A5;
      coef_b = B5;
    end else begin
      over = 1'b1;
    end
  end

  assign lin  = 31'(coef_a) * 31'(s1_code);
  assign diff = $signed({1'b0, lin}) - $signed({2'b00, coef_b});
  assign mag  = diff[31] ? 32'(-diff) : 32'(diff);
  assign x    = mag[29:0] + ROUND_BIAS;

  assign prod = 61'(s2_x) * 61'(RECIP);
  assign quot = prod[RECIP_SH+14:RECIP_SH];

  always_comb begin
    if (s2_over) begin
      sample = FULL_Q88;
    end else if (s2_neg) begin
      sample = -$signed({1'b0, quot});
    end else begin
      sample = $signed({1'b0, quot});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sensor <= in_sensor;
      s1_code   <= in_code;
      s2_sensor <= s1_sensor;
      s2_over   <= over;
      s2_neg    <= diff[31];
      s2_x      <= x;
      s3_sensor <= s2_sensor;
      s3_sample <= sample;
      s3_over   <= s2_over;
    end
  end

  assign smp = '{valid: s3_valid, sensor: s3_sensor, sample: s3_sample, over: s3_over};

endmodule
`default_nettype wire

### design/mpa_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: per-sensor accumulator
// Saturating sum, sample count and clamp flag per sensor; hands a finished
// group to the divider and clears that sensor's state.
// ----------------------------------------------------------------------------
module mpa_accum #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int SENSOR_COUNT        = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire mpa_pkg::sample_t smp,
  output mpa_pkg::group_t       grp
);
  import mpa_pkg::*;

  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [CNT_W-1:0] count [SENSOR_COUNT];
  sum_t             sum   [SENSOR_COUNT];
  logic             clamp [SENSOR_COUNT];

  logic    grp_valid;
  sensor_t grp_sensor;
  sum_t    grp_sum;
  logic    grp_clamp;

  logic [IDX_W+SENSOR_W-1:0] id_ext;
  logic [IDX_W-1:0]          idx;
  logic                      known;
  logic                      last;
  logic signed [SUM_W:0]     total;
  sum_t                      sat;
  logic                      clamp_new;

  assign id_ext    = {IDX_W'(0), smp.sensor};
  assign idx       = id_ext[IDX_W-1:0];
  assign known     = {{(32-SENSOR_W){1'b0}}, smp.sensor} < 32'(SENSOR_COUNT);
  assign last      = (count[idx] == LAST_CNT);
  assign total     = (SUM_W+1)'(sum[idx]) + (SUM_W+1)'(smp.sample);
  assign clamp_new = clamp[idx] | smp.over;

  // saturate when the carry into the sign disagrees
  always_comb begin
    if (total[SUM_W] != total[SUM_W-1]) begin
      sat = total[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat = total[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        count[i] <= '0;
        sum[i]   <= '0;
        clamp[i] <= 1'b0;
      end
    end else if (en) begin
      grp_valid <= smp.valid & known & last;
      if (smp.valid && known) begin
        if (last) begin
          count[idx] <= '0;
          sum[idx]   <= '0;
          clamp[idx] <= 1'b0;
        end else begin
          count[idx] <= count[idx] + 1'b1;
          sum[idx]   <= sat;
          clamp[idx] <= clamp_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_sensor <= smp.sensor;
      grp_sum    <= sat;
      grp_clamp  <= clamp_new;
    end
  end

  assign grp = '{valid: grp_valid, sensor: grp_sensor, sum: grp_sum, clamp: grp_clamp};

endmodule
`default_nettype wire

### design/mpa_avgdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moisture piecewise average: averaging divider and output register
// Divides a group sum by the group size, truncating toward zero, with a
// reciprocal multiply that is exact over the whole sum range.
// ----------------------------------------------------------------------------
module mpa_avgdiv #(
  parameter int SAMPLES_PER_AVERAGE = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire mpa_pkg::group_t grp,
  output logic                 valid,
  output mpa_pkg::sensor_t     sensor_out,
  output mpa_pkg::q88_t        moisture_avg,
  output logic                 clamped
);
  import mpa_pkg::*;

  localparam int SH     = SUM_W + 5;
  localparam int PROD_W = SUM_W + SH + 1;
  localparam logic [SH:0] RECIP_N =
    (SH+1)'(((64'd1 << SH) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]  avg;

  assign mag  = grp.sum[SUM_W-1] ? SUM_W'(-grp.sum) : SUM_W'(grp.sum);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP_N);
  assign quot = prod[SH+SUM_W-1:SH];
  assign avg  = grp.sum[SUM_W-1] ? -quot : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= grp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sensor_out   <= grp.sensor;
      moisture_avg <= $signed(avg[Q_W-1:0]);
      clamped      <= grp.clamp;
    end
  end

endmodule
`default_nettype wire
